>>> src/u2c_pkg.sv
`default_nettype none
package u2c_pkg;

   // First timestamp past the window: 2100-01-01T00:00:00Z
   localparam logic [31:0] LimitSeconds = 32'd4102444800;
   localparam logic [31:0] SecPerDay    = 32'd86400;

   // 86400 = 675 << 7: shift off seven bits, then divide by 675
   localparam int unsigned   DayPreShift = 7;
   localparam longint unsigned DayDiv    = 64'd675;
   localparam int unsigned   DayShift    = 35;
   localparam logic [25:0]   DayMul      =
      26'(((64'd1 << DayShift) + DayDiv - 64'd1) / DayDiv);

   // Four-year cycles counted from 1968-01-01 (a leap year)
   localparam logic [15:0]   EpochOffset = 16'd731;
   localparam logic [11:0]   BaseYear    = 12'd1968;
   localparam logic [15:0]   CycleDays   = 16'd1461;
   localparam longint unsigned CycDiv    = 64'd1461;
   localparam int unsigned   CycShift    = 27;
   localparam logic [16:0]   CycMul      =
      17'(((64'd1 << CycShift) + CycDiv - 64'd1) / CycDiv);
   localparam logic [10:0]   LeapYearDays = 11'd366;
   localparam logic [10:0]   YearDays     = 11'd365;

   // Time of day: exact reciprocal multiplies
   localparam logic [16:0]   SecPerHour = 17'd3600;
   localparam longint unsigned HourDiv  = 64'd3600;
   localparam int unsigned   HourShift  = 29;
   localparam logic [17:0]   HourMul    =
      18'(((64'd1 << HourShift) + HourDiv - 64'd1) / HourDiv);
   localparam logic [11:0]   SecPerMin  = 12'd60;
   localparam longint unsigned MinDiv   = 64'd60;
   localparam int unsigned   MinShift   = 18;
   localparam logic [12:0]   MinMul     =
      13'(((64'd1 << MinShift) + MinDiv - 64'd1) / MinDiv);

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   // Day of year at which a month (0 = January) starts
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage
`default_nettype wire

>>> src/u2c_tod.sv
`default_nettype none
module u2c_tod (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire logic [16:0]   sod,
   output u2c_pkg::tod_type   tod
);

   logic [16:0] sod3_ff;
   logic [4:0]  hour3_ff, hour4_ff, hour5_ff;
   logic [11:0] remh4_ff, remh5_ff;
   logic [5:0]  min5_ff;
   u2c_pkg::tod_type tod6_ff;

   logic [34:0] hour_prod;
   logic [16:0] hour_base;
   logic [16:0] remh_full;
   logic [24:0] min_prod;
   logic [11:0] min_base;
   logic [11:0] sec_full;
   u2c_pkg::tod_type tod_in;

   // Hours by reciprocal multiply, then the remainder within the hour, then minutes and seconds the same way
   always_comb begin
      hour_prod = 35'(sod) * 35'(u2c_pkg::HourMul);
      hour_base = 17'(hour3_ff) * u2c_pkg::SecPerHour;
      remh_full = sod3_ff - hour_base;
      min_prod  = 25'(remh4_ff) * 25'(u2c_pkg::MinMul);
      min_base  = 12'(min5_ff) * u2c_pkg::SecPerMin;
      sec_full  = remh5_ff - min_base;
      tod_in.hour   = hour5_ff;
      tod_in.minute = min5_ff;
      tod_in.second = sec_full[5:0];
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (advance) begin
         sod3_ff  <= sod;
         hour3_ff <= hour_prod[33:29];
         remh4_ff <= remh_full[11:0];
         hour4_ff <= hour3_ff;
         remh5_ff <= remh4_ff;
         min5_ff  <= min_prod[23:18];
         hour5_ff <= hour4_ff;
         tod6_ff  <= tod_in;
      end
   end

   assign tod = tod6_ff;

endmodule
`default_nettype wire

>>> src/u2c_date.sv
`default_nettype none
module u2c_date (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire logic [15:0]   days,
   output u2c_pkg::date_type  date
);

   logic [15:0] dp3_ff;
   logic [5:0]  cyc3_ff, cyc4_ff;
   logic [10:0] rc4_ff;
   logic [11:0] year5_ff;
   logic [8:0]  doy5_ff;
   logic        leap5_ff;
   u2c_pkg::date_type date6_ff;

   logic [15:0] dp;
   logic [32:0] cyc_prod;
   logic [15:0] cyc_base;
   logic [15:0] rc_full;
   logic [10:0] r2;
   logic [1:0]  yidx;
   logic [10:0] doy_full;
   logic [11:0] year_in;
   logic [3:0]  midx;
   logic [8:0]  day_full;
   u2c_pkg::date_type date_in;

   always_comb begin
      // Count four-year cycles since 1968
      dp       = days + u2c_pkg::EpochOffset;
      cyc_prod = 33'(dp) * 33'(u2c_pkg::CycMul);
      cyc_base = 16'(cyc3_ff) * u2c_pkg::CycleDays;
      rc_full  = dp3_ff - cyc_base;

      // Pick the year within the cycle; the leap year comes first
      r2 = rc4_ff - u2c_pkg::LeapYearDays;
      if (rc4_ff < u2c_pkg::LeapYearDays) begin
         yidx     = 2'd0;
         doy_full = rc4_ff;
      end else if (r2 < u2c_pkg::YearDays) begin
         yidx     = 2'd1;
         doy_full = r2;
      end else if (r2 < 11'(2 * 365)) begin
         yidx     = 2'd2;
         doy_full = r2 - u2c_pkg::YearDays;
      end else begin
         yidx     = 2'd3;
         doy_full = r2 - 11'(2 * 365);
      end
      year_in = u2c_pkg::BaseYear + {4'd0, cyc4_ff, 2'b00} + 12'(yidx);

      // Month: count month starts at or below the day of year
      midx = 4'd0;
      for (int m = 1; m < 12; m++) begin
         midx = midx + 4'(doy5_ff >= u2c_pkg::month_start(4'(m), leap5_ff));
      end
      day_full = doy5_ff - u2c_pkg::month_start(midx, leap5_ff) + 9'd1;
      date_in.year  = year5_ff;
      date_in.month = midx + 4'd1;
      date_in.day   = day_full[4:0];
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (advance) begin
         dp3_ff    <= dp;
         cyc3_ff   <= cyc_prod[32:27];
         rc4_ff    <= rc_full[10:0];
         cyc4_ff   <= cyc3_ff;
         year5_ff  <= year_in;
         doy5_ff   <= doy_full[8:0];
         leap5_ff  <= (yidx == 2'd0);
         date6_ff  <= date_in;
      end
   end

   assign date = date6_ff;

endmodule
`default_nettype wire

>>> src/unix_seconds_to_calendar_core.sv
`default_nettype none
// Converts a Unix timestamp in whole seconds into a UTC calendar date and time
// of day for the years 1970 through 2099. The block is a six-stage pipeline
// with one result per timestamp: a timestamp transfer is taken in every cycle
// that the result side keeps up. All stages advance together, so when the
// result at the output register is not taken the whole pipeline holds.
// Timestamps from 2100-01-01 on raise rsp_out_of_range and give zero in every
// other result field.
module unix_seconds_to_calendar_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [31:0] req_unix_seconds,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [11:0] rsp_year,
   output      logic [3:0]  rsp_month,
   output      logic [4:0]  rsp_day,
   output      logic [4:0]  rsp_hour,
   output      logic [5:0]  rsp_minute,
   output      logic [5:0]  rsp_second,
   output      logic        rsp_out_of_range
);

   logic        advance;
   logic [5:0]  valid_ff;
   logic [5:0]  oor_ff;
   logic [31:0] t1_ff;
   logic [15:0] days1_ff, days2_ff;
   logic [16:0] sod2_ff;

   logic [50:0] day_prod;
   logic [31:0] day_base;
   logic [31:0] sod_full;
   u2c_pkg::tod_type  tod;
   u2c_pkg::date_type date;

   // Hold every stage while the result waits
   assign advance   = !valid_ff[5] || rsp_ready;
   assign req_ready = advance;

   // Split into whole days and seconds of day
   always_comb begin
      day_prod = 51'(req_unix_seconds[31:u2c_pkg::DayPreShift]) * 51'(u2c_pkg::DayMul);
      day_base = 32'(days1_ff) * u2c_pkg::SecPerDay;
      sod_full = t1_ff - day_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor_ff   <= {oor_ff[4:0], (req_unix_seconds >= u2c_pkg::LimitSeconds)};
         t1_ff    <= req_unix_seconds;
         days1_ff <= day_prod[50:35];
         days2_ff <= days1_ff;
         sod2_ff  <= sod_full[16:0];
      end
   end

   u2c_tod u_tod (
      .clock   (clock),
      .advance (advance),
      .sod     (sod2_ff),
      .tod     (tod)
   );

   u2c_date u_date (
      .clock   (clock),
      .advance (advance),
      .days    (days2_ff),
      .date    (date)
   );

   // Zero the fields of an out-of-range transfer
   assign rsp_valid        = valid_ff[5];
   assign rsp_out_of_range = oor_ff[5];
   assign rsp_year   = oor_ff[5] ? 12'd0 : date.year;
   assign rsp_month  = oor_ff[5] ? 4'd0  : date.month;
   assign rsp_day    = oor_ff[5] ? 5'd0  : date.day;
   assign rsp_hour   = oor_ff[5] ? 5'd0  : tod.hour;
   assign rsp_minute = oor_ff[5] ? 6'd0  : tod.minute;
   assign rsp_second = oor_ff[5] ? 6'd0  : tod.second;

endmodule
`default_nettype wire

>>> sim/calendar_checker.sv
module calendar_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [31:0] req_unix_seconds,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [11:0] rsp_year,
   input  wire logic [3:0]  rsp_month,
   input  wire logic [4:0]  rsp_day,
   input  wire logic [4:0]  rsp_hour,
   input  wire logic [5:0]  rsp_minute,
   input  wire logic [5:0]  rsp_second,
   input  wire logic        rsp_out_of_range,
   output int unsigned      failures,
   output int unsigned      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FirstYear = 1970;

   typedef struct packed {
      u2c_pkg::date_type date;
      u2c_pkg::tod_type  tod;
      logic              out_of_range;
   } calendar_stamp_type;

   calendar_stamp_type expected_dates [$];
   int unsigned        fail_total = 0;

   function automatic logic leap_year(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int unsigned year_length(input int unsigned year);
      return leap_year(year) ? 366 : 365;
   endfunction

   // Month index 0 is January
   function automatic int unsigned month_length(input int unsigned idx, input logic leap);
      case (idx)
         1:          return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:    return 31;
      endcase
   endfunction

   // Break a timestamp into date and time of day
   function automatic calendar_stamp_type calendar_of(input logic [31:0] stamp);
      calendar_stamp_type stamp_out;
      int unsigned        rest;
      int unsigned        days;
      int unsigned        year;
      int unsigned        month_idx;
      stamp_out = '0;
      if (stamp >= u2c_pkg::LimitSeconds) begin
         stamp_out.out_of_range = 1'b1;
         return stamp_out;
      end
      rest = stamp;
      stamp_out.tod.second = 6'(rest % 60);
      rest = rest / 60;
      stamp_out.tod.minute = 6'(rest % 60);
      rest = rest / 60;
      stamp_out.tod.hour = 5'(rest % 24);
      days = rest / 24;
      // Strip whole years, then whole months
      year = FirstYear;
      while (days >= year_length(year)) begin
         days = days - year_length(year);
         year++;
      end
      month_idx = 0;
      while ((month_idx < 11) && (days >= month_length(month_idx, leap_year(year)))) begin
         days = days - month_length(month_idx, leap_year(year));
         month_idx++;
      end
      stamp_out.date.year  = 12'(year);
      stamp_out.date.month = 4'(month_idx + 1);
      stamp_out.date.day   = 5'(days + 1);
      return stamp_out;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         fail_total++;
         $display("%0t ns: rsp_%s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Match each result transfer against the oldest outstanding timestamp
   always @(posedge clock) begin
      calendar_stamp_type want;
      if (reset) begin
         expected_dates.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               fail_total++;
               $display("%0t ns: result expected none, got %0d-%0d-%0d %0d:%0d:%0d oor=%0d",
                        $time, rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute,
                        rsp_second, rsp_out_of_range);
            end else begin
               want = expected_dates.pop_front();
               check_field("year", want.date.year, rsp_year);
               check_field("month", want.date.month, rsp_month);
               check_field("day", want.date.day, rsp_day);
               check_field("hour", want.tod.hour, rsp_hour);
               check_field("minute", want.tod.minute, rsp_minute);
               check_field("second", want.tod.second, rsp_second);
               check_field("out_of_range", want.out_of_range, rsp_out_of_range);
            end
         end
         if (req_valid && req_ready) begin
            expected_dates.push_back(calendar_of(req_unix_seconds));
         end
      end
      pending  <= expected_dates.size();
      failures <= fail_total;
   end

endmodule

>>> sim/unix_seconds_to_calendar_core_test.sv
module unix_seconds_to_calendar_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomCount = 1800;
   localparam int SteadyFirst = 800;
   localparam int SteadyLast  = 1100;
   localparam int IdlePercent = 33;
   localparam int DrainCycles = 20;
   localparam int LastDay     = 47482;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [31:0] req_unix_seconds = '0;
   logic        rsp_ready        = 1'b0;
   logic        steady           = 1'b0;

   logic        req_ready;
   logic        rsp_valid;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_out_of_range;

   int unsigned mismatches;
   int unsigned outstanding;

   // Epoch, unit rollovers, leap days, year and window ends, top of the input range
   logic [31:0] corner_stamps [16] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169600, 32'd94694399, 32'd951782400, 32'd951868800, 32'd2147483647,
      32'd3981312000, 32'd4102444799, 32'd4102444800, 32'hFFFF_FFFF
   };

   always #10 clock = ~clock;

   unix_seconds_to_calendar_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_out_of_range (rsp_out_of_range)
   );

   calendar_checker calendar_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_out_of_range (rsp_out_of_range),
      .failures         (mismatches),
      .pending          (outstanding)
   );

   // Stall the result side at random, except during the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
   end

   // Idle for a random number of cycles, then hold the timestamp until its transfer
   task automatic send_stamp(input logic [31:0] stamp);
      while (!steady && ($urandom_range(0, 99) < IdlePercent)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_unix_seconds <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      logic [31:0] stamp;
      longint      near_day;
      int          pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_stamps[i]) send_stamp(corner_stamps[i]);
      // Steps of 31 days from 2001-01-01 land in every month
      for (int k = 0; k < 12; k++) begin
         send_stamp(32'd978307200 + 32'(k * 31 * 86400));
      end

      for (int n = 0; n < RandomCount; n++) begin
         steady <= (n >= SteadyFirst) && (n < SteadyLast);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            stamp = $urandom_range(0, u2c_pkg::LimitSeconds - 1);
         end else if (pick < 70) begin
            stamp = $urandom();
         end else if (pick < 92) begin
            // Land a couple of seconds around a midnight
            near_day = longint'($urandom_range(0, LastDay)) * 86400
                       + longint'($urandom_range(0, 4)) - 2;
            if (near_day < 0) near_day = 0;
            stamp = near_day[31:0];
         end else begin
            stamp = u2c_pkg::LimitSeconds - 32'd3 + 32'($urandom_range(0, 5));
         end
         send_stamp(stamp);
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;

      // Drain the pipeline, then watch for stray results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if ((mismatches == 0) && (outstanding == 0)) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
src/u2c_pkg.sv
src/u2c_tod.sv
src/u2c_date.sv
src/unix_seconds_to_calendar_core.sv
sim/calendar_checker.sv
sim/unix_seconds_to_calendar_core_test.sv
